FILE: src/prq_pkg.sv
package prq_pkg;

  // Widest level and task codes over the legal parameter range
  localparam int LVL_MAX_W  = 6;
  localparam int TASK_MAX_W = 8;

  // Command queue between front and back
  localparam int CMD_QUEUE_DEPTH = 2;

  // Item kinds
  localparam logic KIND_ENQUEUE = 1'b0;
  localparam logic KIND_DEQUEUE = 1'b1;

  // One classified command, as the front hands it to the back
  typedef struct packed {
    logic                  kind;
    logic [LVL_MAX_W-1:0]  lvl;
    logic [TASK_MAX_W-1:0] task_id;
  } prq_cmd_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_LINK,
    ST_RESP
  } prq_state_t;

endpackage

FILE: src/priority_ready_queue_bitmap.sv
// Multilevel ready queue with a bitmap of non-empty priority levels.
// Input channel (in_*): one beat is one command. in_tuser is the kind
// (0 enqueue the task, 1 dequeue the head of the level). The level is the
// inherited priority when inherit_active is set, else the base priority.
// Output channel (out_*): one beat per command with the dequeued task, an
// empty flag for a dequeue that found its level empty, and the bitmap of
// non-empty levels after the command.
// An accepted beat passes through the command queue, the back-end sequencer
// (IDLE, LOOK, LINK only for a dequeue that must follow the next link, RESP)
// and the output register. The back end takes a new command only in IDLE,
// after the last one has left RESP. Its steps are head/tail read, list update
// and result load, plus a head write for a dequeue that follows the link.
// A two-beat command queue sits between the front and the back end, so
// in_tready stays high until two commands wait, also while the back end works.
// Reset clears the bitmap, the queue and the output valid; the list stores
// keep old contents, which are only used for levels whose bit is set.
// If the receiver stalls, the result holds in the output register, the
// back end waits and the queue fills; then in_tready drops.
module priority_ready_queue_bitmap
  import prq_pkg::*;
#(
  parameter int NUM_LEVELS = 32,
  parameter int MAX_TASKS  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // base_priority[4:0], inherit_active[5],
                                 // inherited_priority[10:6], task_number[16:11]
  input  logic        in_tuser,  // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata  // dequeued_task[5:0], level_was_empty[6],
                                 // ready_levels[38:7]
);

  logic        q_valid;
  logic        q_pop;
  prq_cmd_t    q_cmd;
  logic [5:0]  dq_task;
  logic        dq_empty;
  logic [31:0] ready_levels;

  prq_front #(
    .NUM_LEVELS (NUM_LEVELS),
    .MAX_TASKS  (MAX_TASKS)
  ) u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_tvalid             (in_tvalid),
    .in_tready             (in_tready),
    .in_kind               (in_tuser),
    .in_base_priority      (in_tdata[4:0]),
    .in_inherit_active     (in_tdata[5]),
    .in_inherited_priority (in_tdata[10:6]),
    .in_task_number        (in_tdata[16:11]),
    .q_valid               (q_valid),
    .q_pop                 (q_pop),
    .q_cmd                 (q_cmd)
  );

  prq_back #(
    .NUM_LEVELS (NUM_LEVELS),
    .MAX_TASKS  (MAX_TASKS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_pop               (q_pop),
    .q_cmd               (q_cmd),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_dequeued_task   (dq_task),
    .out_level_was_empty (dq_empty),
    .out_ready_levels    (ready_levels)
  );

  // Pack the result beat
  assign out_tdata = {1'b0, ready_levels, dq_empty, dq_task};

endmodule

FILE: src/prq_front.sv
module prq_front
  import prq_pkg::*;
#(
  parameter int NUM_LEVELS = 32,
  parameter int MAX_TASKS  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_kind,
  input  logic [4:0]  in_base_priority,
  input  logic        in_inherit_active,
  input  logic [4:0]  in_inherited_priority,
  input  logic [5:0]  in_task_number,
  output logic        q_valid,
  input  logic        q_pop,
  output prq_cmd_t    q_cmd
);

  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int PW = $clog2(CMD_QUEUE_DEPTH);
  localparam int CW = $clog2(CMD_QUEUE_DEPTH + 1);

  typedef logic [31:0][LW-1:0] lvl_tab_t;
  typedef logic [63:0][TW-1:0] task_tab_t;

  // Wrap tables, built at elaboration
  function automatic lvl_tab_t build_lvl_tab();
    lvl_tab_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = LW'(i % NUM_LEVELS);
    end
    return t;
  endfunction

  function automatic task_tab_t build_task_tab();
    task_tab_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = TW'(i % MAX_TASKS);
    end
    return t;
  endfunction

  localparam lvl_tab_t  LVL_TAB  = build_lvl_tab();
  localparam task_tab_t TASK_TAB = build_task_tab();

  prq_cmd_t          fifo_r [CMD_QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic [4:0]        prio_sel;
  prq_cmd_t          cmd_in;
  logic              push;
  logic              pop;

  // Classify: pick the effective level and wrap level and task
  always_comb begin
    prio_sel       = in_inherit_active ? in_inherited_priority : in_base_priority;
    cmd_in.kind    = in_kind;
    cmd_in.lvl     = LVL_MAX_W'(LVL_TAB[prio_sel]);
    cmd_in.task_id = TASK_MAX_W'(TASK_TAB[in_task_number]);
  end

  assign in_tready = (count_r != CW'(CMD_QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_cmd     = fifo_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: src/prq_back.sv
module prq_back
  import prq_pkg::*;
#(
  parameter int NUM_LEVELS = 32,
  parameter int MAX_TASKS  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  prq_cmd_t    q_cmd,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [5:0]  out_dequeued_task,
  output logic        out_level_was_empty,
  output logic [31:0] out_ready_levels
);

  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  // Linked-list stores
  logic [TW-1:0] head_mem [NUM_LEVELS];
  logic [TW-1:0] tail_mem [NUM_LEVELS];
  logic [TW-1:0] link_mem [MAX_TASKS];

  prq_state_t            state_r, state_nxt;
  logic                  kind_r;
  logic [LW-1:0]         lvl_r;
  logic [TW-1:0]         task_r;
  logic [TW-1:0]         head_rd_r;
  logic [TW-1:0]         tail_rd_r;
  logic [TW-1:0]         link_rd_r;
  logic [NUM_LEVELS-1:0] bitmap_r, bitmap_nxt;
  logic [TW-1:0]         res_task_r, res_task_nxt;
  logic                  res_empty_r, res_empty_nxt;
  logic                  out_valid_r;
  logic [5:0]            out_task_r;
  logic                  out_empty_r;
  logic [31:0]           out_levels_r;

  logic                  hit;
  logic                  head_we, tail_we, link_we, link_re;
  logic [TW-1:0]         head_wd;
  logic                  out_load;
  logic [TASK_MAX_W-1:0] res_task_ext;
  logic [63:0]           bitmap_ext;

  assign hit      = bitmap_r[lvl_r];
  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign out_load = (state_r == ST_RESP) && (!out_valid_r || out_tready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        if (kind_r == KIND_DEQUEUE && hit && head_rd_r != tail_rd_r) begin
          state_nxt = ST_LINK;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_LINK: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Store writes, bitmap update and result for each state
  always_comb begin
    head_we       = 1'b0;
    tail_we       = 1'b0;
    link_we       = 1'b0;
    link_re       = 1'b0;
    head_wd       = task_r;
    bitmap_nxt    = bitmap_r;
    res_task_nxt  = res_task_r;
    res_empty_nxt = res_empty_r;
    case (state_r)
      ST_LOOK: begin
        if (kind_r == KIND_ENQUEUE) begin
          res_task_nxt  = '0;
          res_empty_nxt = 1'b0;
          tail_we       = 1'b1;
          if (!hit) begin
            head_we           = 1'b1;
            bitmap_nxt[lvl_r] = 1'b1;
          end else begin
            link_we = 1'b1;
          end
        end else if (!hit) begin
          res_task_nxt  = '0;
          res_empty_nxt = 1'b1;
        end else begin
          res_task_nxt  = head_rd_r;
          res_empty_nxt = 1'b0;
          if (head_rd_r == tail_rd_r) begin
            bitmap_nxt[lvl_r] = 1'b0;
          end else begin
            link_re = 1'b1;
          end
        end
      end
      ST_LINK: begin
        // advance the head to the successor of the removed task
        head_we = 1'b1;
        head_wd = link_rd_r;
      end
      default: begin
      end
    endcase
  end

  // Head and tail stores: read on command pop, write at the level in flight
  always_ff @(posedge clk) begin
    if (q_pop) begin
      head_rd_r <= head_mem[q_cmd.lvl[LW-1:0]];
      tail_rd_r <= tail_mem[q_cmd.lvl[LW-1:0]];
    end
    if (head_we) head_mem[lvl_r] <= head_wd;
    if (tail_we) tail_mem[lvl_r] <= task_r;
  end

  // Next-link store: written behind the old tail, read at the head
  always_ff @(posedge clk) begin
    if (link_re) link_rd_r <= link_mem[head_rd_r];
    if (link_we) link_mem[tail_rd_r] <= task_r;
  end

  // Command in flight and result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= q_cmd.kind;
      lvl_r  <= q_cmd.lvl[LW-1:0];
      task_r <= q_cmd.task_id[TW-1:0];
    end
    res_task_r  <= res_task_nxt;
    res_empty_r <= res_empty_nxt;
  end

  assign res_task_ext = TASK_MAX_W'(res_task_r);
  assign bitmap_ext   = 64'(bitmap_r);

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_task_r   <= res_task_ext[5:0];
      out_empty_r  <= res_empty_r;
      out_levels_r <= bitmap_ext[31:0];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bitmap_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      bitmap_r <= bitmap_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid          = out_valid_r;
  assign out_dequeued_task   = out_task_r;
  assign out_level_was_empty = out_empty_r;
  assign out_ready_levels    = out_levels_r;

endmodule
